>>> rtl/core/sinelfo_pkg.sv
// Shared types and constants of the sine LFO phase accumulator.
package sinelfo_pkg;

	localparam int PERIOD_W = 24;
	localparam int WAVE_W = 16;
	localparam int CFG_DATA_W = 32;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_LFO_ENABLED = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SYNC_MODE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BIPOLAR_MODE = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SYNC_INCREMENT = 2'd3;

	localparam int CORDIC_STEPS = 24;
	localparam int STEP_IDX_W = 5;
	localparam int XY_W = 34;
	localparam int Z_W = 33;
	localparam int ANGLE_W = 31;
	localparam logic signed [XY_W-1:0] CORDIC_X0 = 34'sd652032874;
	localparam logic [ANGLE_W-1:0] HALF_PI_Q30 = 31'd1686629713;
	localparam int MAG_W = 15;
	localparam logic [MAG_W-1:0] MAG_MAX = 15'd32767;

	localparam logic [31:0] ATAN_Q30 [CORDIC_STEPS] = '{
		32'd843314857, 32'd497837830, 32'd263043837, 32'd133525159,
		32'd67021687, 32'd33543516, 32'd16775851, 32'd8388437,
		32'd4194283, 32'd2097149, 32'd1048576, 32'd524288,
		32'd262144, 32'd131072, 32'd65536, 32'd32768,
		32'd16384, 32'd8192, 32'd4096, 32'd2048,
		32'd1024, 32'd512, 32'd256, 32'd128
	};

	typedef enum logic {
		ST_IDLE,
		ST_CALC
	} lfo_state_t;

endpackage

>>> rtl/core/sinelfo_if.sv
// Valid/ready channels that carry LFO input and result items.
interface sinelfo_in_if;
	import sinelfo_pkg::*;
	logic valid;
	logic ready;
	logic [PERIOD_W-1:0] period_samples;
	modport source (output valid, output period_samples, input ready);
	modport sink (input valid, input period_samples, output ready);
endinterface

interface sinelfo_out_if;
	import sinelfo_pkg::*;
	logic valid;
	logic ready;
	logic signed [WAVE_W-1:0] wave_value;
	logic is_bipolar;
	modport source (output valid, output wave_value, output is_bipolar, input ready);
	modport sink (input valid, input wave_value, input is_bipolar, output ready);
endinterface

>>> rtl/core/sine_lfo_phase_accumulator.sv
// Sine LFO: phase accumulator with bit-serial reciprocal divider and iterative CORDIC.
// One item is worked on at a time, by the restoring divider (one quotient bit per cycle)
// running alongside the 24-step CORDIC; a new item is taken once the result is loaded.
// The output register frees the input side while a result waits to be taken.
// Reset clears configuration, phase and all control state.
module sine_lfo_phase_accumulator #(
	parameter int PHASE_BITS = 32,
	parameter int SINE_TABLE_BITS = 10
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [sinelfo_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [sinelfo_pkg::CFG_DATA_W-1:0] cfg_data,
	sinelfo_in_if.sink lfo_in,
	sinelfo_out_if.source lfo_out
);
	import sinelfo_pkg::*;

	localparam int FIN = (PHASE_BITS + 1 > CORDIC_STEPS + 2) ? PHASE_BITS + 1
		: CORDIC_STEPS + 2;
	localparam int CNT_W = $clog2(FIN + 1);
	localparam int K_W = SINE_TABLE_BITS + 1;
	localparam int PROD_W = K_W + ANGLE_W;

	logic lfo_enabled_q;
	logic sync_mode_q;
	logic bipolar_mode_q;
	logic [31:0] sync_increment_q;
	logic [PHASE_BITS-1:0] phase_q;

	lfo_state_t state_q, state_d;
	logic [CNT_W-1:0] cnt_q;
	logic [1:0] quad_q;
	logic [K_W-1:0] k_q;
	logic [PERIOD_W-1:0] per_q;
	logic [PERIOD_W-1:0] rem_q;
	logic [PHASE_BITS-1:0] quo_q;
	logic signed [XY_W-1:0] x_q, y_q;
	logic signed [Z_W-1:0] z_q;
	logic [MAG_W-1:0] mag_q;
	logic out_valid_q;
	logic signed [WAVE_W-1:0] wave_q;
	logic bip_q;

	logic accept, at_fin, load;
	logic [1:0] quad_in;
	logic [SINE_TABLE_BITS-1:0] k_raw;
	logic [K_W-1:0] k_in;
	logic [PERIOD_W-1:0] per_in;
	logic [PROD_W-1:0] angle_prod;
	logic [PERIOD_W-1:0] rem_prev;
	logic [PERIOD_W:0] rem_sh, rem_sub;
	logic div_ge;
	logic [STEP_IDX_W-1:0] step_idx;
	logic signed [XY_W-1:0] dx, dy;
	logic signed [Z_W-1:0] atan_z;
	logic [XY_W-2:0] y_pos;
	logic [47:0] mag_sum;
	logic [17:0] mag_raw;
	logic [16:0] s_val, u_val;
	logic signed [WAVE_W-1:0] wave_d;
	logic [PHASE_BITS+31:0] sync_wide;
	logic [PHASE_BITS-1:0] inc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lfo_enabled_q <= 1'b0;
			sync_mode_q <= 1'b0;
			bipolar_mode_q <= 1'b0;
			sync_increment_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_LFO_ENABLED: lfo_enabled_q <= cfg_data[0];
				CFG_SYNC_MODE: sync_mode_q <= cfg_data[0];
				CFG_BIPOLAR_MODE: bipolar_mode_q <= cfg_data[0];
				CFG_SYNC_INCREMENT: sync_increment_q <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	assign lfo_in.ready = (state_q == ST_IDLE);
	assign accept = lfo_in.valid && lfo_in.ready;
	assign at_fin = (state_q == ST_CALC) && (cnt_q == CNT_W'(FIN));
	assign load = at_fin && (!out_valid_q || lfo_out.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (accept) state_d = ST_CALC;
			ST_CALC: if (load) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (accept) begin
			cnt_q <= '0;
		end else if (state_q == ST_CALC && !at_fin) begin
			cnt_q <= cnt_q + CNT_W'(1);
		end
	end

	// Capture sine index and saturated period.
	assign quad_in = phase_q[PHASE_BITS-1 -: 2];
	assign k_raw = phase_q[PHASE_BITS-3 -: SINE_TABLE_BITS];
	assign k_in = quad_in[0] ? (K_W'(1) << SINE_TABLE_BITS) - K_W'(k_raw) : K_W'(k_raw);
	assign per_in = (lfo_in.period_samples < PERIOD_W'(2)) ? PERIOD_W'(2)
		: lfo_in.period_samples;

	always_ff @(posedge clk) begin
		if (accept) begin
			quad_q <= quad_in;
			k_q <= k_in;
			per_q <= per_in;
		end
	end

	// Restoring division of 2^PHASE_BITS, one quotient bit per cycle.
	assign rem_prev = (cnt_q == '0) ? '0 : rem_q;
	assign rem_sh = {rem_prev, (cnt_q == '0)};
	assign div_ge = rem_sh >= {1'b0, per_q};
	assign rem_sub = rem_sh - {1'b0, per_q};

	always_ff @(posedge clk) begin
		if (state_q == ST_CALC && cnt_q <= CNT_W'(PHASE_BITS)) begin
			rem_q <= div_ge ? rem_sub[PERIOD_W-1:0] : rem_sh[PERIOD_W-1:0];
			quo_q <= {quo_q[PHASE_BITS-2:0], div_ge};
		end
	end

	// CORDIC rotation, one micro-rotation per cycle.
	assign angle_prod = PROD_W'(k_q) * PROD_W'(HALF_PI_Q30);
	assign step_idx = STEP_IDX_W'(cnt_q - CNT_W'(1));
	assign dx = y_q >>> step_idx;
	assign dy = x_q >>> step_idx;
	assign atan_z = $signed({1'b0, ATAN_Q30[step_idx]});

	always_ff @(posedge clk) begin
		if (state_q == ST_CALC) begin
			if (cnt_q == '0) begin
				z_q <= $signed(Z_W'(angle_prod >> SINE_TABLE_BITS));
				x_q <= CORDIC_X0;
				y_q <= '0;
			end else if (cnt_q <= CNT_W'(CORDIC_STEPS)) begin
				if (z_q >= 0) begin
					x_q <= x_q - dx;
					y_q <= y_q + dy;
					z_q <= z_q - atan_z;
				end else begin
					x_q <= x_q + dx;
					y_q <= y_q - dy;
					z_q <= z_q + atan_z;
				end
			end
		end
	end

	// Scale to Q1.15 with rounding and clamp.
	assign y_pos = y_q[XY_W-1] ? '0 : y_q[XY_W-2:0];
	assign mag_sum = {y_pos[32:0], 15'b0} - 48'(y_pos) + (48'(1) << 29);
	assign mag_raw = mag_sum[47:30];

	always_ff @(posedge clk) begin
		if (state_q == ST_CALC && cnt_q == CNT_W'(CORDIC_STEPS + 1)) begin
			mag_q <= (mag_raw > 18'(MAG_MAX)) ? MAG_MAX : mag_raw[MAG_W-1:0];
		end
	end

	assign s_val = quad_q[1] ? -{2'b00, mag_q} : {2'b00, mag_q};
	assign u_val = s_val + 17'd32768;

	always_comb begin
		if (!lfo_enabled_q) begin
			wave_d = '0;
		end else if (bipolar_mode_q) begin
			wave_d = $signed(s_val[WAVE_W-1:0]);
		end else begin
			wave_d = $signed(u_val[16:1]);
		end
	end

	// Advance phase.
	assign sync_wide = {sync_increment_q, PHASE_BITS'(0)};
	assign inc = sync_mode_q ? sync_wide[PHASE_BITS+31:32] : quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
		end else if (load && lfo_enabled_q) begin
			phase_q <= phase_q + inc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (lfo_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			wave_q <= wave_d;
			bip_q <= lfo_enabled_q && bipolar_mode_q;
		end
	end

	assign lfo_out.valid = out_valid_q;
	assign lfo_out.wave_value = wave_q;
	assign lfo_out.is_bipolar = bip_q;

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_CALC) && (cnt_q == '0))
		else $error("accepted item did not start computation");

	a_load_at_fin: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> (cnt_q == CNT_W'(FIN)) && (state_q == ST_CALC))
		else $error("result loaded before computation finished");

	a_phase_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!load |=> $stable(phase_q))
		else $error("phase changed outside result load");

	a_disabled_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(load && !lfo_enabled_q) |=> $stable(phase_q) && (wave_q == '0) && !bip_q)
		else $error("disabled item changed phase or gave nonzero result");

endmodule

>>> bench/tb_sine_lfo_phase_accumulator.sv
`timescale 1ns / 100ps
// Self-checking testbench for the sine LFO phase accumulator: directed table, then random items.
module tb_sine_lfo_phase_accumulator;
	import sinelfo_pkg::*;

	localparam int SETTLE = 40;
	localparam int CYCLE_LIMIT = 600000;
	localparam int SEGMENT_ITEMS = 100;
	localparam int QUARTER = 1024;

	localparam longint ATAN_TAB [24] = '{
		843314857, 497837830, 263043837, 133525159, 67021687, 33543516,
		16775851, 8388437, 4194283, 2097149, 1048576, 524288,
		262144, 131072, 65536, 32768, 16384, 8192,
		4096, 2048, 1024, 512, 256, 128
	};

	typedef struct packed {
		logic en;
		logic sync;
		logic bip;
		logic [31:0] inc;
	} lfo_setting_t;

	typedef struct packed {
		logic signed [WAVE_W-1:0] value;
		logic bip;
	} wave_t;

	typedef struct packed {
		lfo_setting_t set;
		logic [PERIOD_W-1:0] period;
		logic typed;
		wave_t wave;
	} lfo_row_t;

	localparam lfo_setting_t S_OFF = '{1'b0, 1'b0, 1'b0, 32'h0000_0000};
	localparam lfo_setting_t S_OFF_BIP = '{1'b0, 1'b1, 1'b1, 32'hFFFF_FFFF};
	localparam lfo_setting_t S_QTR_BIP = '{1'b1, 1'b1, 1'b1, 32'h4000_0000};
	localparam lfo_setting_t S_QTR_UNI = '{1'b1, 1'b1, 1'b0, 32'h4000_0000};
	localparam lfo_setting_t S_FREE_BIP = '{1'b1, 1'b0, 1'b1, 32'h0000_0000};
	localparam lfo_setting_t S_FREE_UNI = '{1'b1, 1'b0, 1'b0, 32'h4000_0000};
	localparam lfo_setting_t S_HALF_STEP = '{1'b1, 1'b1, 1'b1, 32'h8000_0000};
	localparam lfo_setting_t S_FULL_STEP = '{1'b1, 1'b1, 1'b0, 32'hFFFF_FFFF};
	localparam lfo_setting_t S_ZERO_STEP = '{1'b1, 1'b1, 1'b1, 32'h0000_0000};

	localparam int ROWS = 25;
	localparam lfo_row_t VECTORS [ROWS] = '{
		'{S_OFF, 24'h000000, 1'b1, '{16'sd0, 1'b0}},
		'{S_OFF_BIP, 24'hFFFFFF, 1'b1, '{16'sd0, 1'b0}},
		'{S_QTR_BIP, 24'h000000, 1'b1, '{16'sd0, 1'b1}},
		'{S_QTR_BIP, 24'hFFFFFF, 1'b1, '{16'sd32767, 1'b1}},
		'{S_QTR_BIP, 24'h000001, 1'b1, '{16'sd0, 1'b1}},
		'{S_QTR_BIP, 24'h000002, 1'b1, '{-16'sd32767, 1'b1}},
		'{S_QTR_UNI, 24'h000000, 1'b1, '{16'sd16384, 1'b0}},
		'{S_QTR_UNI, 24'h000005, 1'b1, '{16'sd32767, 1'b0}},
		'{S_QTR_UNI, 24'h000000, 1'b1, '{16'sd16384, 1'b0}},
		'{S_QTR_UNI, 24'h000000, 1'b1, '{16'sd0, 1'b0}},
		'{S_OFF, 24'h000003, 1'b1, '{16'sd0, 1'b0}},
		'{S_FREE_BIP, 24'h000000, 1'b1, '{16'sd0, 1'b1}},
		'{S_FREE_BIP, 24'h000001, 1'b1, '{16'sd0, 1'b1}},
		'{S_FREE_BIP, 24'h000002, 1'b1, '{16'sd0, 1'b1}},
		'{S_FREE_BIP, 24'hFFFFFF, 1'b0, '0},
		'{S_FREE_BIP, 24'h000003, 1'b0, '0},
		'{S_FREE_BIP, 24'h000004, 1'b0, '0},
		'{S_FREE_UNI, 24'h800000, 1'b0, '0},
		'{S_FREE_UNI, 24'h5A5A5A, 1'b0, '0},
		'{S_HALF_STEP, 24'h000000, 1'b0, '0},
		'{S_HALF_STEP, 24'h000000, 1'b0, '0},
		'{S_FULL_STEP, 24'hA5A5A5, 1'b0, '0},
		'{S_FULL_STEP, 24'h000000, 1'b0, '0},
		'{S_ZERO_STEP, 24'h000007, 1'b0, '0},
		'{S_ZERO_STEP, 24'h000007, 1'b0, '0}
	};

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	sinelfo_in_if lfo_in();
	sinelfo_out_if lfo_out();

	sine_lfo_phase_accumulator uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.lfo_in(lfo_in),
		.lfo_out(lfo_out)
	);

	int quarter_wave [0:QUARTER];
	lfo_setting_t setting;
	logic [31:0] phase_acc;
	wave_t wave_queue [$];
	int errors = 0;
	int cycles = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;

	function automatic int cordic_quarter(input int k);
		longint z;
		longint x;
		longint y;
		longint dx;
		longint dy;
		longint r;
		z = (longint'(k) * 64'sd1686629713) >>> 10;
		x = 652032874;
		y = 0;
		for (int i = 0; i < 24; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x = x - dx;
				y = y + dy;
				z = z - ATAN_TAB[i];
			end else begin
				x = x + dx;
				y = y - dy;
				z = z + ATAN_TAB[i];
			end
		end
		if (y < 0)
			y = 0;
		r = (y * 32767 + (64'sd1 <<< 29)) >>> 30;
		if (r > 32767)
			r = 32767;
		return int'(r);
	endfunction

	function automatic wave_t predict_wave(input logic [PERIOD_W-1:0] period);
		wave_t w;
		logic [1:0] quad;
		int idx;
		int s;
		int shifted;
		logic [63:0] quo;
		logic [31:0] step;
		w = '0;
		if (setting.en) begin
			quad = phase_acc[31:30];
			idx = int'(phase_acc[29:20]);
			if (quad[0])
				idx = QUARTER - idx;
			s = quad[1] ? -quarter_wave[idx] : quarter_wave[idx];
			if (setting.bip) begin
				w.value = s[15:0];
				w.bip = 1'b1;
			end else begin
				shifted = (s + 32768) >>> 1;
				w.value = shifted[15:0];
				w.bip = 1'b0;
			end
			if (setting.sync) begin
				step = setting.inc;
			end else begin
				quo = 64'h1_0000_0000 / ((period < 2) ? 64'd2 : {40'd0, period});
				step = quo[31:0];
			end
			phase_acc = phase_acc + step;
		end
		return w;
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
	endtask

	task automatic apply_setting(input lfo_setting_t s);
		lfo_in.valid <= 1'b0;
		while (wave_queue.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		write_reg(CFG_LFO_ENABLED, {31'($urandom()), s.en});
		write_reg(CFG_SYNC_MODE, {31'($urandom()), s.sync});
		write_reg(CFG_BIPOLAR_MODE, {31'($urandom()), s.bip});
		write_reg(CFG_SYNC_INCREMENT, s.inc);
		cfg_we <= 1'b0;
		setting = s;
	endtask

	task automatic send_item(input logic [PERIOD_W-1:0] period, input logic typed, input wave_t typed_wave);
		wave_t w;
		if ($urandom_range(99) < send_idle_pct) begin
			lfo_in.valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < send_idle_pct);
		end
		lfo_in.valid <= 1'b1;
		lfo_in.period_samples <= period;
		do
			@(posedge clk);
		while (!lfo_in.ready);
		w = predict_wave(period);
		wave_queue.push_back(typed ? typed_wave : w);
	endtask

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAIL sine_lfo_phase_accumulator");
			$finish;
		end
	end

	always @(posedge clk) begin : result_check
		wave_t want;
		if (arst_n && lfo_out.valid && lfo_out.ready) begin
			if (wave_queue.size() == 0) begin
				errors++;
				$display("%0t: unexpected item: value %0d bipolar %0b", $time,
					lfo_out.wave_value, lfo_out.is_bipolar);
			end else begin
				want = wave_queue.pop_front();
				if (want.value !== lfo_out.wave_value || want.bip !== lfo_out.is_bipolar) begin
					errors++;
					$display("%0t: expected value %0d bipolar %0b, got value %0d bipolar %0b",
						$time, want.value, want.bip, lfo_out.wave_value, lfo_out.is_bipolar);
				end
			end
		end
		lfo_out.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	initial begin
		lfo_setting_t s;
		logic [PERIOD_W-1:0] period;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_LFO_ENABLED;
		cfg_data <= '0;
		lfo_in.valid <= 1'b0;
		lfo_in.period_samples <= '0;
		setting = '0;
		phase_acc = '0;
		for (int k = 0; k <= QUARTER; k++)
			quarter_wave[k] = cordic_quarter(k);
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < ROWS; i++) begin
			if (i == 0 || VECTORS[i].set != setting)
				apply_setting(VECTORS[i].set);
			send_item(VECTORS[i].period, VECTORS[i].typed, VECTORS[i].wave);
		end

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 74;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 74;
				end
				default: begin
					send_idle_pct = 8;
					recv_stall_pct = 8;
				end
			endcase
			for (int seg = 0; seg < 4; seg++) begin
				s.en = ($urandom_range(99) < 88);
				s.sync = 1'($urandom_range(1));
				s.bip = 1'($urandom_range(1));
				case ($urandom_range(5))
					0: s.inc = 32'h0000_0000;
					1: s.inc = 32'hFFFF_FFFF;
					2: s.inc = 32'h8000_0000;
					3: s.inc = $urandom_range(1, 1 << 20);
					default: s.inc = $urandom();
				endcase
				apply_setting(s);
				repeat (SEGMENT_ITEMS) begin
					case ($urandom_range(9))
						0: period = PERIOD_W'($urandom_range(3));
						1: period = 24'hFFFFFF;
						2, 3, 4: period = PERIOD_W'($urandom_range(2, 64));
						5, 6: period = PERIOD_W'($urandom_range(65, 100000));
						default: period = PERIOD_W'($urandom());
					endcase
					send_item(period, 1'b0, '0);
				end
			end
		end

		lfo_in.valid <= 1'b0;
		while (wave_queue.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (errors == 0)
			$display("PASS sine_lfo_phase_accumulator");
		else
			$display("FAIL sine_lfo_phase_accumulator");
		$finish;
	end

endmodule

>>> files.f
rtl/core/sinelfo_pkg.sv
rtl/core/sinelfo_if.sv
rtl/core/sine_lfo_phase_accumulator.sv
bench/tb_sine_lfo_phase_accumulator.sv
